// ----- src/fpsdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsdc_pkg
// Shared types and constants for the single/double precision converter.
// ----------------------------------------------------------------------------
package fpsdc_pkg;

  localparam logic OP_WIDEN  = 1'b0;
  localparam logic OP_NARROW = 1'b1;

  localparam int unsigned DATA_W = 64;

  // double exponent bounds for narrowing (biased)
  localparam logic [10:0] D_EXP_MAX     = 11'h7FF;
  localparam logic [10:0] D_EXP_OVF     = 11'd1150; // above: infinity
  localparam logic [10:0] D_EXP_UNF     = 11'd873;  // below: zero
  localparam logic [10:0] D_EXP_DEN     = 11'd897;  // below: single denormal
  localparam logic [10:0] D_EXP_S_BIAS  = 11'd896;  // 1023 - 127
  localparam logic [7:0]  S_EXP_MAX     = 8'hFF;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_INF_NAN,
    CLS_NORMAL,
    CLS_DENORM,
    CLS_OVF
  } cls_t;

  typedef struct packed {
    logic        op;
    logic        sign;
    cls_t        cls;
    logic [10:0] expo;
    logic [51:0] frac;
    logic [4:0]  shamt;
  } s1_t;

  typedef struct packed {
    logic        op;
    logic        sign;
    cls_t        cls;
    logic [10:0] expo;
    logic [51:0] frac;
    logic [23:0] mant;
  } s2_t;

endpackage

// ----- src/fpsdc_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsdc_decode
// Classifies the operand and computes the normalize/denormalize shift.
// ----------------------------------------------------------------------------
module fpsdc_decode (
  input  logic                 op,
  input  logic [63:0]          operand,
  output fpsdc_pkg::s1_t       dec
);
  import fpsdc_pkg::*;

  logic [7:0]  ef;
  logic [22:0] fr;
  logic [4:0]  lead;
  logic [10:0] de;

  assign ef = operand[30:23];
  assign fr = operand[22:0];
  assign de = operand[62:52];

  // leading one position of the single fraction
  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (fr[i]) begin
        lead = 5'(i);
      end
    end
  end

  always_comb begin
    dec.op    = op;
    dec.shamt = 5'd0;
    if (op == OP_WIDEN) begin
      dec.sign = operand[31];
      dec.expo = {3'b000, ef};
      dec.frac = {29'd0, fr};
      if (ef == S_EXP_MAX) begin
        dec.cls = CLS_INF_NAN;
      end else if (ef == 8'd0) begin
        dec.cls   = (fr == 23'd0) ? CLS_ZERO : CLS_DENORM;
        dec.shamt = 5'd23 - lead;
      end else begin
        dec.cls = CLS_NORMAL;
      end
    end else begin
      dec.sign  = operand[63];
      dec.expo  = de;
      dec.frac  = operand[51:0];
      dec.shamt = 5'(D_EXP_DEN - de);
      if (de == D_EXP_MAX) begin
        dec.cls = CLS_INF_NAN;
      end else if (de > D_EXP_OVF) begin
        dec.cls = CLS_OVF;
      end else if (de < D_EXP_UNF) begin
        dec.cls = CLS_ZERO;
      end else if (de < D_EXP_DEN) begin
        dec.cls = CLS_DENORM;
      end else begin
        dec.cls = CLS_NORMAL;
      end
    end
  end

endmodule

// ----- src/fpsdc_shift.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsdc_shift
// Barrel shift stage: normalizes single denormals, aligns single denormals.
// ----------------------------------------------------------------------------
module fpsdc_shift (
  input  fpsdc_pkg::s1_t dec,
  output fpsdc_pkg::s2_t sh
);
  import fpsdc_pkg::*;

  logic [24:0] den_m;
  logic [22:0] norm_f;

  assign den_m  = {1'b1, dec.frac[51:28]} >> dec.shamt;
  assign norm_f = dec.frac[22:0] << dec.shamt;

  always_comb begin
    sh.op   = dec.op;
    sh.sign = dec.sign;
    sh.cls  = dec.cls;
    sh.expo = dec.expo;
    sh.frac = dec.frac;
    sh.mant = dec.frac[51:28];
    if (dec.op == OP_WIDEN) begin
      if (dec.cls == CLS_DENORM) begin
        sh.expo = D_EXP_DEN - {6'd0, dec.shamt};
        sh.frac = {29'd0, norm_f};
      end
    end else if (dec.cls == CLS_DENORM) begin
      sh.mant = den_m[23:0];
    end
  end

endmodule

// ----- src/fpsdc_pack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsdc_pack
// Rounds the narrowed mantissa and assembles the result bit pattern.
// ----------------------------------------------------------------------------
module fpsdc_pack (
  input  fpsdc_pkg::s2_t sh,
  output logic [63:0]    result
);
  import fpsdc_pkg::*;

  logic [24:0] rnd;
  logic        carry;
  logic [7:0]  sexp;
  logic [22:0] nan_f;

  assign rnd   = {1'b0, sh.mant} + 25'd1;
  assign carry = rnd[24];
  assign sexp  = ((sh.cls == CLS_DENORM) ? 8'd0 : 8'(sh.expo - D_EXP_S_BIAS))
                 + {7'd0, carry};
  assign nan_f = sh.frac[51:29] | ((sh.frac != 52'd0) ? 23'h400000 : 23'd0);

  always_comb begin
    if (sh.op == OP_WIDEN) begin
      unique case (sh.cls)
        CLS_ZERO:    result = {sh.sign, 63'd0};
        CLS_INF_NAN: result = {sh.sign, 11'h7FF, sh.frac[22:0], 29'd0};
        CLS_NORMAL:  result = {sh.sign, sh.expo + D_EXP_S_BIAS, sh.frac[22:0], 29'd0};
        CLS_DENORM:  result = {sh.sign, sh.expo, sh.frac[22:0], 29'd0};
        default:     result = {sh.sign, 63'd0};
      endcase
    end else begin
      unique case (sh.cls)
        CLS_ZERO:    result = {32'd0, sh.sign, 31'd0};
        CLS_INF_NAN: result = {32'd0, sh.sign, S_EXP_MAX, nan_f};
        CLS_OVF:     result = {32'd0, sh.sign, S_EXP_MAX, 23'd0};
        CLS_NORMAL,
        CLS_DENORM:  result = {32'd0, sh.sign, sexp, carry ? 23'd0 : rnd[23:1]};
        default:     result = {32'd0, sh.sign, 31'd0};
      endcase
    end
  end

endmodule

// ----- src/fp_single_double_convert_top.sv -----
`timescale 1ns / 1ps
// A transaction passes through the decode, shift and round/pack stage registers to the result.
// Throughput: one transaction per cycle while out_stall is low; the three stage registers bound it.
// A stall holds the output register and back-pressures each full stage whose successors are all full.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// fp_single_double_convert_top
// IEEE 754 single <-> double bit-pattern converter, three-stage pipeline.
// ----------------------------------------------------------------------------
module fp_single_double_convert_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [63:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_bits
);
  import fpsdc_pkg::*;

  // stage payloads
  s1_t         dec_nxt, s1_r;
  s2_t         sh_nxt, s2_r;
  logic [63:0] res_nxt, s3_r;
  logic        s3_op_r;
  logic        s1_v_r, s2_v_r, s3_v_r;

  // per-stage load enables: a stage loads when empty or when its
  // successor loads (or drains to the output)
  logic en3, en2, en1;

  assign en3 = !s3_v_r || !out_stall;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;

  assign in_stall        = !en1;
  assign out_valid       = s3_v_r;
  assign out_result_bits = s3_r;

  fpsdc_decode u_decode (
    .op      (in_opcode),
    .operand (in_operand_bits),
    .dec     (dec_nxt)
  );

  fpsdc_shift u_shift (
    .dec (s1_r),
    .sh  (sh_nxt)
  );

  fpsdc_pack u_pack (
    .sh     (s2_r),
    .result (res_nxt)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en1) s1_r <= dec_nxt;
    if (en2) s2_r <= sh_nxt;
    if (en3) begin
      s3_r    <= res_nxt;
      s3_op_r <= s2_r.op;
    end
  end

`ifndef SYNTHESIS
  // a narrowed result never has upper bits set
  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s3_op_r == OP_NARROW) |-> (s3_r[63:32] == 32'd0))
    else $error("narrow result has nonzero upper word");

  // an accepted transaction lands in stage one
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_v_r)
    else $error("accepted transaction lost at stage one");

  // back-pressure only when every stage holds data
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r))
    else $error("input stalled with an empty stage");

  // reset empties the pipe
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!s1_v_r && !s2_v_r && !s3_v_r))
    else $error("valid bits not cleared by reset");
`endif

endmodule
